### src/pngu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types, register map, filter codes and the Paeth predictor for the
// PNG scanline reconstruction block.
// ----------------------------------------------------------------------------
package pngu_pkg;

    typedef logic [7:0] t_byte;

    localparam int ROW_BYTES_W   = 14;
    localparam int PIXEL_BYTES_W = 4;

    typedef logic [ROW_BYTES_W-1:0]   t_row_bytes;
    typedef logic [PIXEL_BYTES_W-1:0] t_pixel_bytes;

    localparam t_row_bytes   RST_ROW_BYTES   = 14'd4;
    localparam t_pixel_bytes RST_PIXEL_BYTES = 4'd4;

    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    localparam t_byte FILT_NONE  = 8'd0;
    localparam t_byte FILT_SUB   = 8'd1;
    localparam t_byte FILT_UP    = 8'd2;
    localparam t_byte FILT_AVG   = 8'd3;
    localparam t_byte FILT_PAETH = 8'd4;

    function automatic t_byte paeth(input t_byte a, input t_byte b, input t_byte c);
        logic signed [9:0] d_bc;
        logic signed [9:0] d_ac;
        logic signed [9:0] d_sum;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        t_byte             res;
        d_bc  = signed'({2'b00, b}) - signed'({2'b00, c});
        d_ac  = signed'({2'b00, a}) - signed'({2'b00, c});
        d_sum = d_bc + d_ac;
        pa    = d_bc[9]  ? unsigned'(-d_bc)  : unsigned'(d_bc);
        pb    = d_ac[9]  ? unsigned'(-d_ac)  : unsigned'(d_ac);
        pc    = d_sum[9] ? unsigned'(-d_sum) : unsigned'(d_sum);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### src/pngu_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngu_in_if
// Stream channel carrying filtered bytes of the decompressed image.
// ----------------------------------------------------------------------------
interface pngu_in_if
    import pngu_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte filtered_byte;
    logic  start_of_image;

    modport source (output valid, output filtered_byte, output start_of_image, input ready);
    modport sink   (input valid, input filtered_byte, input start_of_image, output ready);
endinterface
`default_nettype wire

### src/pngu_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pngu_out_if
// Stream channel carrying reconstructed image bytes and row status.
// ----------------------------------------------------------------------------
interface pngu_out_if
    import pngu_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte pixel_byte;
    logic  end_of_row;
    logic  bad_filter;

    modport source (output valid, output pixel_byte, output end_of_row, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input end_of_row, input bad_filter,
                    output ready);
endinterface
`default_nettype wire

### src/png_scanline_unfilter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth).
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless the output stalls; a sample
// beat passes the reconstruction stage and output registers to its result
// beat. The line store is read when a sample is taken, so its registered read
// data meets the sample in the reconstruction stage, and the Sub, Average and
// Paeth feedback through the left history closes within that single stage.
// Filter bytes give no result beat. The line store needs no clearing after
// reset, as every row must be preceded by a row at least as long since reset.
module png_scanline_unfilter
    import pngu_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pngu_in_if.sink      i_in,
    pngu_out_if.source   o_out,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int LW = (CW > ROW_BYTES_W) ? CW : ROW_BYTES_W;

    typedef struct packed {
        t_byte         raw;
        t_byte         filt;
        logic          first;
        logic          ge;
        logic [PW-1:0] ring;
        logic [AW-1:0] idx;
        logic          eor;
    } t_s2;

    typedef struct packed {
        t_byte pixel_byte;
        logic  end_of_row;
        logic  bad_filter;
    } t_res;

    t_row_bytes    r_row_bytes;
    t_pixel_bytes  r_bpp;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          r_first;
    logic          n_first;
    t_byte         r_filter;
    t_byte         n_filter;
    logic [PW-1:0] r_mod [MAX_PIXEL_BYTES];
    logic [PW-1:0] n_mod [MAX_PIXEL_BYTES];
    logic          r_s2_valid;
    t_s2           r_s2;
    t_byte         r_up;
    t_byte         r_line [MAX_ROW_BYTES];
    t_byte         r_left [MAX_PIXEL_BYTES];
    t_byte         r_ul   [MAX_PIXEL_BYTES];
    logic          r_o_valid;
    t_res          r_o;

    logic          w_cfg_wr;
    logic [LW-1:0] w_len;
    t_pixel_bytes  w_bpp;
    t_pixel_bytes  w_bsel;
    logic          w_acc;
    logic          w_s2_adv;
    logic [CW-1:0] w_col;
    logic [CW-1:0] w_col_m1;
    logic          w_first;
    logic          w_is_filter;
    logic [AW-1:0] w_idx;
    logic [PW-1:0] w_ring;
    logic          w_ge;
    logic          w_eor;
    t_byte         w_a;
    t_byte         w_b;
    t_byte         w_c;
    logic [8:0]    w_sum;
    t_byte         w_pred;
    t_byte         w_val;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= RST_ROW_BYTES;
            r_bpp       <= RST_PIXEL_BYTES;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_ROW_BYTES:   r_row_bytes <= pwdata[ROW_BYTES_W-1:0];
                REG_PIXEL_BYTES: r_bpp       <= pwdata[PIXEL_BYTES_W-1:0];
                default:         r_bpp       <= r_bpp;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_BYTES:   prdata = 32'(r_row_bytes);
            REG_PIXEL_BYTES: prdata = 32'(r_bpp);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        if (r_row_bytes == '0) begin
            w_len = LW'(1);
        end else if (LW'(r_row_bytes) > LW'(MAX_ROW_BYTES)) begin
            w_len = LW'(MAX_ROW_BYTES);
        end else begin
            w_len = LW'(r_row_bytes);
        end
        if (r_bpp == '0) begin
            w_bpp = t_pixel_bytes'(1);
        end else if (r_bpp > t_pixel_bytes'(MAX_PIXEL_BYTES)) begin
            w_bpp = t_pixel_bytes'(MAX_PIXEL_BYTES);
        end else begin
            w_bpp = r_bpp;
        end
    end

    assign w_s2_adv    = r_s2_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready  = !r_s2_valid || w_s2_adv;
    assign w_acc       = i_in.valid && i_in.ready;

    assign w_col       = i_in.start_of_image ? '0 : r_col;
    assign w_first     = i_in.start_of_image ? 1'b1 : r_first;
    assign w_is_filter = (w_col == '0);
    assign w_col_m1    = w_col - CW'(1);
    assign w_idx       = w_col_m1[AW-1:0];
    assign w_bsel      = w_bpp - t_pixel_bytes'(1);
    assign w_ring      = r_mod[w_bsel[PW-1:0]];
    assign w_ge        = LW'(w_idx) >= LW'(w_bpp);
    assign w_eor       = LW'(w_col) >= w_len;

    always_comb begin
        n_col    = r_col;
        n_first  = r_first;
        n_filter = r_filter;
        n_mod    = r_mod;
        if (w_acc) begin
            if (w_is_filter) begin
                n_filter = i_in.filtered_byte;
                n_col    = CW'(1);
                n_first  = w_first;
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    n_mod[k] = '0;
                end
            end else begin
                if (w_eor) begin
                    n_col   = '0;
                    n_first = 1'b0;
                end else begin
                    n_col   = w_col + CW'(1);
                    n_first = w_first;
                end
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    n_mod[k] = (r_mod[k] == PW'(k)) ? '0 : r_mod[k] + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_first  <= 1'b1;
            r_filter <= FILT_NONE;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_mod[k] <= '0;
            end
        end else begin
            r_col    <= n_col;
            r_first  <= n_first;
            r_filter <= n_filter;
            r_mod    <= n_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_acc && !w_is_filter) begin
            r_s2_valid <= 1'b1;
        end else if (w_s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_is_filter) begin
            r_s2.raw   <= i_in.filtered_byte;
            r_s2.filt  <= r_filter;
            r_s2.first <= w_first;
            r_s2.ge    <= w_ge;
            r_s2.ring  <= w_ring;
            r_s2.idx   <= w_idx;
            r_s2.eor   <= w_eor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_is_filter) begin
            r_up <= r_line[w_idx];
        end
        if (w_s2_adv) begin
            r_line[r_s2.idx] <= w_val;
        end
    end

    always_comb begin
        w_a   = r_s2.ge ? r_left[r_s2.ring] : '0;
        w_b   = r_s2.first ? '0 : r_up;
        w_c   = (r_s2.ge && !r_s2.first) ? r_ul[r_s2.ring] : '0;
        w_sum = {1'b0, w_a} + {1'b0, w_b};
        case (r_s2.filt)
            FILT_SUB:   w_pred = w_a;
            FILT_UP:    w_pred = w_b;
            FILT_AVG:   w_pred = w_sum[8:1];
            FILT_PAETH: w_pred = paeth(w_a, w_b, w_c);
            default:    w_pred = '0;
        endcase
        w_val = r_s2.raw + w_pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k] <= '0;
                r_ul[k]   <= '0;
            end
        end else if (w_s2_adv) begin
            r_left[r_s2.ring] <= w_val;
            r_ul[r_s2.ring]   <= w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s2_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_o.pixel_byte <= w_val;
            r_o.end_of_row <= r_s2.eor;
            r_o.bad_filter <= (r_s2.filt > FILT_PAETH);
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.pixel_byte = r_o.pixel_byte;
    assign o_out.end_of_row = r_o.end_of_row;
    assign o_out.bad_filter = r_o.bad_filter;

`ifndef SYNTH
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s2_valid))
        else $error("result beat appeared without a sample in the reconstruction stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s2_valid && r_o_valid && !o_out.ready))
        else $error("input stalled while the pipeline could still advance");

    a_ring_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2.ge) |-> (LW'(r_s2.ring) == LW'(r_s2.idx)))
        else $error("history ring position out of step with the column in the first pixel");
`endif

endmodule
`default_nettype wire
